>>> hw/rtl/matrix_multiply_defines.svh
// Assertion macros shared by the matrix multiply checker.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define MM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("matrix_multiply assertion failed");

// Next-cycle implication, ignored while in reset.
`define MM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("matrix_multiply assertion failed");

// Property checked on the cycle after reset is sampled low.
`define MM_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("matrix_multiply reset assertion failed");

`endif

>>> hw/rtl/mm_pkg.sv
// Shared types, constants and helpers for the matrix multiply block.
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DIM_W       = 4;
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 32;
    localparam int RES_W       = 35;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_A  = 2'd0,
        CMD_WR_B  = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_INNER_COUNT = 2'd1,
        CFG_COL_COUNT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_WR_A,
        OP_WR_B,
        OP_START
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VAL_W-1:0]   value;
    } t_op;

    typedef struct packed {
        logic [DIM_W-1:0] row_count;
        logic [DIM_W-1:0] inner_count;
        logic [DIM_W-1:0] col_count;
    } t_dims;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [RES_W-1:0] result_value;
        logic                    last;
    } t_result;

    // Zero reads as one, anything above max_dim reads as max_dim.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                   input int max_dim);
        logic [DIM_W-1:0] v;
        v = raw;
        if (v == '0) begin
            v = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            v = DIM_W'(max_dim);
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mm_fifo.sv
// Small command queue between the front and back parts.
module mm_fifo #(
    parameter int DEPTH = mm_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  mm_pkg::t_op i_data,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_valid,
    output mm_pkg::t_op o_data
);
    import mm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_op             r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/mm_front.sv
// Front part: accepts input transfers, decodes them and queues valid operations.
module mm_front #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mm_pkg::CMD_W-1:0]  i_command,
    input  logic [mm_pkg::IDX_W-1:0]  i_row,
    input  logic [mm_pkg::IDX_W-1:0]  i_col,
    input  logic [mm_pkg::VAL_W-1:0]  i_value,
    input  logic                      i_pop,
    output logic                      o_op_valid,
    output mm_pkg::t_op               o_op
);
    import mm_pkg::*;

    logic in_range;
    logic keep;
    logic full;
    t_op  op;

    assign in_range = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);

    always_comb begin
        op.row   = i_row;
        op.col   = i_col;
        op.value = i_value;
        op.kind  = OP_START;
        keep     = 1'b0;
        unique case (i_command)
            CMD_WR_A: begin
                op.kind = OP_WR_A;
                keep    = in_range;
            end
            CMD_WR_B: begin
                op.kind = OP_WR_B;
                keep    = in_range;
            end
            CMD_START: begin
                op.kind = OP_START;
                keep    = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Dropped items are still taken so the stream keeps moving.
    assign o_ready = !full;

    mm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && o_ready && keep),
        .i_data  (op),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_valid (o_op_valid),
        .o_data  (o_op)
    );

endmodule

>>> hw/rtl/mm_back.sv
// Back part: element stores, index sequencer, multiply-accumulate pipeline.
module mm_back #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_op_valid,
    input  mm_pkg::t_op     i_op,
    output logic            o_op_pop,
    input  mm_pkg::t_dims   i_dims,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output mm_pkg::t_result o_res
);
    import mm_pkg::*;

    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SD = MAX_DIM * MAX_DIM;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_out;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    logic                     stall;
    logic                     pop;
    logic                     start;
    logic                     issue;
    logic                     k_end;
    logic                     j_end;
    logic                     i_end;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr_a;
    logic [AW-1:0]            raddr_b;
    logic [VAL_W-1:0]         rdata_a;
    logic [VAL_W-1:0]         rdata_b;
    t_tag                     tag;
    logic signed [RES_W-1:0]  sum;

    logic                     r_busy, n_busy;
    logic [DW-1:0]            r_i, n_i;
    logic [DW-1:0]            r_j, n_j;
    logic [DW-1:0]            r_k, n_k;
    logic [DW-1:0]            r_i_last, n_i_last;
    logic [DW-1:0]            r_j_last, n_j_last;
    logic [DW-1:0]            r_k_last, n_k_last;
    logic                     r_v1;
    t_tag                     r_t1;
    logic                     r_v2;
    t_tag                     r_t2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RES_W-1:0]  r_acc;
    logic                     r_res_valid;
    t_result                  r_res;

    assign stall = r_res_valid && !i_res_ready;
    assign pop   = i_op_valid && !r_busy && !stall;
    assign start = pop && (i_op.kind == OP_START);
    assign issue = r_busy && !stall;
    assign k_end = (r_k == r_k_last);
    assign j_end = (r_j == r_j_last);
    assign i_end = (r_i == r_i_last);

    assign waddr   = AW'(i_op.row) * AW'(MAX_DIM) + AW'(i_op.col);
    assign raddr_a = AW'(r_i) * AW'(MAX_DIM) + AW'(r_k);
    assign raddr_b = AW'(r_k) * AW'(MAX_DIM) + AW'(r_j);

    assign tag.first    = (r_k == '0);
    assign tag.last_k   = k_end;
    assign tag.last_out = k_end && j_end && i_end;
    assign tag.row      = IDX_W'(r_i);
    assign tag.col      = IDX_W'(r_j);

    always_comb begin
        n_busy   = r_busy;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_i_last = r_i_last;
        n_j_last = r_j_last;
        n_k_last = r_k_last;
        if (start) begin
            n_busy   = 1'b1;
            n_i      = '0;
            n_j      = '0;
            n_k      = '0;
            n_i_last = DW'(i_dims.row_count - DIM_W'(1));
            n_j_last = DW'(i_dims.col_count - DIM_W'(1));
            n_k_last = DW'(i_dims.inner_count - DIM_W'(1));
        end else if (issue) begin
            if (!k_end) begin
                n_k = r_k + DW'(1);
            end else begin
                n_k = '0;
                if (!j_end) begin
                    n_j = r_j + DW'(1);
                end else begin
                    n_j = '0;
                    if (!i_end) begin
                        n_i = r_i + DW'(1);
                    end else begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
    end

    mm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SD)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (pop && (i_op.kind == OP_WR_A)),
        .i_waddr (waddr),
        .i_wdata (i_op.value),
        .i_re    (!stall),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SD)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (pop && (i_op.kind == OP_WR_B)),
        .i_waddr (waddr),
        .i_wdata (i_op.value),
        .i_re    (!stall),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign sum = (r_t2.first ? RES_W'(0) : r_acc) + RES_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (!stall) begin
                r_v1        <= issue;
                r_v2        <= r_v1;
                r_res_valid <= r_v2 && r_t2.last_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_i_last <= n_i_last;
        r_j_last <= n_j_last;
        r_k_last <= n_k_last;
        if (!stall) begin
            r_t1   <= tag;
            r_t2   <= r_t1;
            r_prod <= $signed(rdata_a) * $signed(rdata_b);
            if (r_v2) begin
                r_acc <= sum;
            end
            if (r_v2 && r_t2.last_k) begin
                r_res.out_row      <= r_t2.row;
                r_res.out_col      <= r_t2.col;
                r_res.result_value <= sum;
                r_res.last         <= r_t2.last_out;
            end
        end
    end

    assign o_op_pop    = pop;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> hw/rtl/matrix_multiply.sv
// Top level: C = A x B over signed Q8.8 elements with exact Q19.16 results.
// Load transfers: one per cycle while the four deep queue is not full; the back part takes loads only while
//   no product is running. Start: results come out row by row, one per output element, with one read of
//   each store per cycle while the output is not stalled.
// Reset (synchronous, active low) clears control and sets all dimensions to 8;
//   the element stores keep their contents and are not cleared.
module matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // row[2:0], col[5:3], value[21:6], zero pad
    input  logic [mm_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // command[1:0]
    input  logic [mm_pkg::CMD_W-1:0]        i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_row[2:0], out_col[5:3], result_value[40:6], zero pad
    output logic [mm_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]        i_cfg_data
);
    import mm_pkg::*;

    logic [DIM_W-1:0] r_row_count;
    logic [DIM_W-1:0] r_inner_count;
    logic [DIM_W-1:0] r_col_count;
    t_dims            dims;
    logic             op_valid;
    t_op              op;
    logic             op_pop;
    t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= DIM_RESET;
            r_inner_count <= DIM_RESET;
            r_col_count   <= DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                CFG_INNER_COUNT: r_inner_count <= i_cfg_data;
                CFG_COL_COUNT:   r_col_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign dims.row_count   = clamp_dim(r_row_count, MAX_DIM);
    assign dims.inner_count = clamp_dim(r_inner_count, MAX_DIM);
    assign dims.col_count   = clamp_dim(r_col_count, MAX_DIM);

    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_command  (i_s_axis_tuser),
        .i_row      (i_s_axis_tdata[IDX_W-1:0]),
        .i_col      (i_s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_value    (i_s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
        .i_pop      (op_pop),
        .o_op_valid (op_valid),
        .o_op       (op)
    );

    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_pop    (op_pop),
        .i_dims      (dims),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {(M_TDATA_W - 2*IDX_W - RES_W)'(0), res.result_value,
                             res.out_col, res.out_row};
    assign o_m_axis_tlast = res.last;

endmodule

>>> hw/rtl/matrix_multiply_checker.sv
// Port-level checker for the matrix multiply block, bound to the top level.
`include "matrix_multiply_defines.svh"

module matrix_multiply_checker #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [mm_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                          o_m_axis_tlast
);
    import mm_pkg::*;

    logic               out_stall;
    logic [M_TDATA_W:0] out_beat;
    logic               index_ok;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_beat  = {o_m_axis_tlast, o_m_axis_tdata};
    assign index_ok  = (32'(o_m_axis_tdata[IDX_W-1:0]) < MAX_DIM)
                    && (32'(o_m_axis_tdata[2*IDX_W-1:IDX_W]) < MAX_DIM);

    `MM_ASSERT_RST(a_no_out_after_reset, !o_m_axis_tvalid)

    `MM_ASSERT_NXT(a_out_hold, out_stall, o_m_axis_tvalid && $stable(out_beat))

    `MM_ASSERT_IMP(a_index_range, o_m_axis_tvalid, index_ok)

    `MM_ASSERT_IMP(a_pad_zero, o_m_axis_tvalid, o_m_axis_tdata[M_TDATA_W-1:2*IDX_W+RES_W] == '0)

endmodule

bind matrix_multiply matrix_multiply_checker #(.MAX_DIM(MAX_DIM)) u_checker (.*);
